FILE: rtl/core/rfus_pkg.sv
// shared types, widths and codes of the regularized flow update solver
package rfus_pkg;

  localparam int WW     = 16;
  localparam int PRW    = 2 * WW;
  localparam int ACCW   = 36;
  localparam int JW     = 38;
  localparam int MW     = 2 * JW;
  localparam int PW     = MW + 1;
  localparam int NW     = PW + 8;
  localparam int QSTEPS = 18;
  localparam int TW     = PW + QSTEPS - 1;
  localparam int MCW    = $clog2(JW);
  localparam int DCW    = $clog2(QSTEPS);
  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] REG_ZERO   = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_SAME   = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_SMOOTH = CFG_IW'(2);

  localparam logic [WW-1:0] RST_ZERO   = WW'(0);
  localparam logic [WW-1:0] RST_SAME   = WW'(655);
  localparam logic [WW-1:0] RST_SMOOTH = WW'(655);

  typedef struct packed {
    logic signed [WW-1:0] channel_diff;
    logic signed [WW-1:0] grad_x_sum;
    logic signed [WW-1:0] grad_y_sum;
    logic signed [WW-1:0] flow_x;
    logic signed [WW-1:0] flow_y;
    logic signed [WW-1:0] flow_dx_x;
    logic signed [WW-1:0] flow_dx_y;
    logic signed [WW-1:0] flow_dy_x;
    logic signed [WW-1:0] flow_dy_y;
    logic                 last_channel;
  } in_item_t;

  typedef struct packed {
    logic signed [WW-1:0] update_x;
    logic signed [WW-1:0] update_y;
    logic                 singular;
  } out_item_t;

  typedef struct packed {
    logic signed [JW-1:0] a;
    logic signed [JW-1:0] b;
    logic signed [JW-1:0] c;
    logic signed [JW-1:0] rx;
    logic signed [JW-1:0] ry;
  } job_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_LOAD    = 6'b000010,
    S_MUL     = 6'b000100,
    S_DIVLOAD = 6'b001000,
    S_DIV     = 6'b010000,
    S_OUT     = 6'b100000
  } solve_state_t;

endpackage

FILE: rtl/core/rfus_front.sv
// front end: weight registers, channel products, accumulation and system setup
module rfus_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  rfus_pkg::in_item_t           in_data,
  output logic                         in_full,
  input  logic                         cfg_we,
  input  logic [rfus_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rfus_pkg::WW-1:0]      cfg_data,
  input  logic [rfus_pkg::QCW-1:0]     q_count,
  output logic                         job_push,
  output rfus_pkg::job_t               job
);
  import rfus_pkg::*;

  logic [WW-1:0] wz_r, wsame_r, ws_r;
  logic          accept;
  logic          s1_valid_r, s1_last_r;
  logic signed [PRW-1:0]   p_gxgx_r, p_gxgy_r, p_gygy_r, p_gxd_r, p_gyd_r;
  logic signed [PRW:0]     p_zx_r, p_zy_r;
  logic signed [PRW+1:0]   p_sx_r, p_sy_r;
  logic signed [WW:0]      fsum_x, fsum_y;
  logic signed [ACCW-1:0]  sum_gxgx_r, sum_gxgy_r, sum_gygy_r, sum_gxd_r, sum_gyd_r;
  logic signed [ACCW-1:0]  n_gxgx, n_gxgy, n_gygy, n_gxd, n_gyd;
  logic [WW+1:0]           wsum;
  logic [JW-1:0]           diag;
  logic [QCW:0]            pending;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wz_r    <= RST_ZERO;
      wsame_r <= RST_SAME;
      ws_r    <= RST_SMOOTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZERO:   wz_r    <= cfg_data;
        REG_SAME:   wsame_r <= cfg_data;
        REG_SMOOTH: ws_r    <= cfg_data;
        default:    ;
      endcase
    end
  end

  // reserve a queue slot for a last channel still in the product stage
  assign pending = {1'b0, q_count} + (QCW+1)'(s1_valid_r & s1_last_r);
  assign in_full = (pending >= (QCW+1)'(QDEPTH));
  assign accept  = in_push && !in_full;

  assign fsum_x = {in_data.flow_dx_x[WW-1], in_data.flow_dx_x}
                + {in_data.flow_dy_x[WW-1], in_data.flow_dy_x};
  assign fsum_y = {in_data.flow_dx_y[WW-1], in_data.flow_dx_y}
                + {in_data.flow_dy_y[WW-1], in_data.flow_dy_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) s1_last_r <= in_data.last_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_gxgx_r <= in_data.grad_x_sum * in_data.grad_x_sum;
      p_gxgy_r <= in_data.grad_x_sum * in_data.grad_y_sum;
      p_gygy_r <= in_data.grad_y_sum * in_data.grad_y_sum;
      p_gxd_r  <= in_data.grad_x_sum * in_data.channel_diff;
      p_gyd_r  <= in_data.grad_y_sum * in_data.channel_diff;
      p_zx_r   <= $signed({1'b0, wz_r}) * in_data.flow_x;
      p_zy_r   <= $signed({1'b0, wz_r}) * in_data.flow_y;
      p_sx_r   <= $signed({1'b0, ws_r}) * fsum_x;
      p_sy_r   <= $signed({1'b0, ws_r}) * fsum_y;
    end
  end

  assign n_gxgx = sum_gxgx_r + {{(ACCW-PRW){p_gxgx_r[PRW-1]}}, p_gxgx_r};
  assign n_gxgy = sum_gxgy_r + {{(ACCW-PRW){p_gxgy_r[PRW-1]}}, p_gxgy_r};
  assign n_gygy = sum_gygy_r + {{(ACCW-PRW){p_gygy_r[PRW-1]}}, p_gygy_r};
  assign n_gxd  = sum_gxd_r  + {{(ACCW-PRW){p_gxd_r[PRW-1]}},  p_gxd_r};
  assign n_gyd  = sum_gyd_r  + {{(ACCW-PRW){p_gyd_r[PRW-1]}},  p_gyd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_gxgx_r <= '0;
      sum_gxgy_r <= '0;
      sum_gygy_r <= '0;
      sum_gxd_r  <= '0;
      sum_gyd_r  <= '0;
    end else if (s1_valid_r) begin
      sum_gxgx_r <= s1_last_r ? '0 : n_gxgx;
      sum_gxgy_r <= s1_last_r ? '0 : n_gxgy;
      sum_gygy_r <= s1_last_r ? '0 : n_gygy;
      sum_gxd_r  <= s1_last_r ? '0 : n_gxd;
      sum_gyd_r  <= s1_last_r ? '0 : n_gyd;
    end
  end

  assign wsum = {2'b00, wz_r} + {2'b00, wsame_r} + {1'b0, ws_r, 1'b0};
  assign diag = JW'({wsum, 10'b0});

  assign job_push = s1_valid_r && s1_last_r;
  assign job.a  = {{(JW-ACCW){n_gxgx[ACCW-1]}}, n_gxgx} + $signed(diag);
  assign job.b  = {{(JW-ACCW){n_gxgy[ACCW-1]}}, n_gxgy};
  assign job.c  = {{(JW-ACCW){n_gygy[ACCW-1]}}, n_gygy} + $signed(diag);
  assign job.rx = {{(JW-ACCW){n_gxd[ACCW-1]}}, n_gxd}
                + {{(JW-PRW-3){p_zx_r[PRW]}}, p_zx_r, 2'b00}
                + {{(JW-PRW-4){p_sx_r[PRW+1]}}, p_sx_r, 2'b00};
  assign job.ry = {{(JW-ACCW){n_gyd[ACCW-1]}}, n_gyd}
                + {{(JW-PRW-3){p_zy_r[PRW]}}, p_zy_r, 2'b00}
                + {{(JW-PRW-4){p_sy_r[PRW+1]}}, p_sy_r, 2'b00};

endmodule

FILE: rtl/core/rfus_queue.sv
// short job queue between front end and solver
module rfus_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  rfus_pkg::job_t            job_in,
  input  logic                      pop,
  output rfus_pkg::job_t            head,
  output logic                      empty,
  output logic [rfus_pkg::QCW-1:0]  count
);
  import rfus_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic           do_pop;

  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + QCW'(push) - QCW'(do_pop);
    end
  end

endmodule

FILE: rtl/core/rfus_solver.sv
// back end: shift-add products, determinant, restoring quotients, result register
module rfus_solver (
  input  logic                clk,
  input  logic                rst_n,
  input  rfus_pkg::job_t      job,
  input  logic                job_valid,
  output logic                job_pop,
  output rfus_pkg::out_item_t out_data,
  output logic                out_empty,
  input  logic                out_pop
);
  import rfus_pkg::*;

  localparam logic [2:0] OP_AC  = 3'd0;
  localparam logic [2:0] OP_BB  = 3'd1;
  localparam logic [2:0] OP_CRX = 3'd2;
  localparam logic [2:0] OP_BRY = 3'd3;
  localparam logic [2:0] OP_ARY = 3'd4;
  localparam logic [2:0] OP_BRX = 3'd5;
  localparam logic [QSTEPS-1:0] Q_MAXP = QSTEPS'(32767);
  localparam logic [QSTEPS-1:0] Q_MAXN = QSTEPS'(32768);

  solve_state_t state_r, state_nxt;
  job_t                  job_r;
  logic [2:0]            op_r;
  logic [MW-1:0]         acc_r, mc_r, acc_sum;
  logic [JW-1:0]         mp_r;
  logic [MCW-1:0]        mcnt_r;
  logic                  mneg_r;
  logic signed [PW-1:0]  tmp_r, det_r, nx_r, ny_r, prod_u, prod_s, comb;
  logic signed [JW-1:0]  opx, opy;
  logic [NW-1:0]         rem_r;
  logic [TW-1:0]         dsh_r;
  logic [QSTEPS-1:0]     quot_r, quot_nxt;
  logic [DCW-1:0]        dcnt_r;
  logic                  dneg_r, sel_r, ge, mul_done, div_done;
  logic signed [PW-1:0]  num;
  logic [WW-1:0]         qsat;
  logic signed [WW-1:0]  ux_r, uy_r;
  logic                  sing_r;
  out_item_t             res_r;
  logic                  res_valid_r, res_load;

  function automatic logic [JW-1:0] mag_j(input logic signed [JW-1:0] v);
    return v[JW-1] ? JW'(-v) : JW'(v);
  endfunction

  function automatic logic [PW-1:0] mag_p(input logic signed [PW-1:0] v);
    return v[PW-1] ? PW'(-v) : PW'(v);
  endfunction

  always_comb begin
    unique case (op_r)
      OP_AC:   begin opx = job_r.a; opy = job_r.c;  end
      OP_BB:   begin opx = job_r.b; opy = job_r.b;  end
      OP_CRX:  begin opx = job_r.c; opy = job_r.rx; end
      OP_BRY:  begin opx = job_r.b; opy = job_r.ry; end
      OP_ARY:  begin opx = job_r.a; opy = job_r.ry; end
      OP_BRX:  begin opx = job_r.b; opy = job_r.rx; end
      default: begin opx = job_r.a; opy = job_r.c;  end
    endcase
  end

  assign acc_sum  = acc_r + (mp_r[0] ? mc_r : '0);
  assign prod_u   = $signed({1'b0, acc_sum});
  assign prod_s   = mneg_r ? -prod_u : prod_u;
  assign comb     = tmp_r - prod_s;
  assign mul_done = (mcnt_r == MCW'(JW-1));

  assign num      = sel_r ? ny_r : nx_r;
  assign ge       = ({{(TW-NW){1'b0}}, rem_r} >= dsh_r);
  assign quot_nxt = {quot_r[QSTEPS-2:0], ge};
  assign div_done = (dcnt_r == '0);

  always_comb begin
    if (dneg_r) begin
      qsat = (quot_nxt > Q_MAXN) ? 16'h8000 : (~quot_nxt[WW-1:0]) + 16'd1;
    end else begin
      qsat = (quot_nxt > Q_MAXP) ? 16'h7FFF : quot_nxt[WW-1:0];
    end
  end

  assign res_load  = (state_r == S_OUT) && (!res_valid_r || out_pop);
  assign job_pop   = (state_r == S_IDLE) && job_valid;
  assign out_empty = !res_valid_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (job_valid) state_nxt = S_LOAD;
      S_LOAD:    state_nxt = S_MUL;
      S_MUL:     if (mul_done) state_nxt = (op_r == OP_BRX) ? S_DIVLOAD : S_LOAD;
      S_DIVLOAD: state_nxt = (det_r == '0) ? S_OUT : S_DIV;
      S_DIV:     if (div_done) state_nxt = sel_r ? S_OUT : S_DIVLOAD;
      S_OUT:     if (res_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) res_valid_r <= 1'b1;
      else if (out_pop) res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) job_r <= job;
        op_r  <= OP_AC;
        sel_r <= 1'b0;
      end
      S_LOAD: begin
        mc_r   <= MW'(mag_j(opx));
        mp_r   <= mag_j(opy);
        mneg_r <= opx[JW-1] ^ opy[JW-1];
        acc_r  <= '0;
        mcnt_r <= '0;
      end
      S_MUL: begin
        acc_r  <= acc_sum;
        mc_r   <= mc_r << 1;
        mp_r   <= mp_r >> 1;
        mcnt_r <= mcnt_r + MCW'(1);
        if (mul_done) begin
          op_r <= op_r + 3'd1;
          if (!op_r[0]) begin
            tmp_r <= prod_s;
          end else begin
            unique case (op_r)
              OP_BB:   det_r <= comb;
              OP_BRY:  nx_r  <= comb;
              default: ny_r  <= comb;
            endcase
          end
        end
      end
      S_DIVLOAD: begin
        if (det_r == '0) begin
          ux_r   <= '0;
          uy_r   <= '0;
          sing_r <= 1'b1;
        end else begin
          sing_r <= 1'b0;
          dneg_r <= num[PW-1] ^ det_r[PW-1];
          rem_r  <= {mag_p(num), 8'b0};
          dsh_r  <= {mag_p(det_r), {(QSTEPS-1){1'b0}}};
          quot_r <= '0;
          dcnt_r <= DCW'(QSTEPS-1);
        end
      end
      S_DIV: begin
        if (ge) rem_r <= rem_r - dsh_r[NW-1:0];
        dsh_r  <= dsh_r >> 1;
        quot_r <= quot_nxt;
        dcnt_r <= dcnt_r - DCW'(1);
        if (div_done) begin
          sel_r <= 1'b1;
          if (sel_r) uy_r <= $signed(qsat);
          else ux_r <= $signed(qsat);
        end
      end
      S_OUT: begin
        if (res_load) begin
          res_r.update_x <= ux_r;
          res_r.update_y <= uy_r;
          res_r.singular <= sing_r;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/regularized_flow_update_solver.sv
// top level of the regularized flow update solver
// path of a pixel: its last channel passes the product register and the job queue to the
//   solver, which forms six products in turn and then two quotients (none for a singular system)
// throughput: one channel per cycle while the job queue has room;
//   the solver takes one pixel at a time and pops another job only when idle, as it
//   holds a single shared shift-add multiplier and a single restoring divider
// reset: synchronous, active low; clears sums, queue and result, loads default weights
module regularized_flow_update_solver (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  rfus_pkg::in_item_t           in_data,
  output logic                         in_full,
  output logic                         out_empty,
  input  logic                         out_pop,
  output rfus_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [rfus_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rfus_pkg::WW-1:0]      cfg_data
);
  import rfus_pkg::*;

  job_t           job_in, job_head;
  logic [QCW-1:0] q_count;
  logic           job_push;
  logic           q_empty, job_pop;

  rfus_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_count   (q_count),
    .job_push  (job_push),
    .job       (job_in)
  );

  rfus_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .job_in (job_in),
    .pop    (job_pop),
    .head   (job_head),
    .empty  (q_empty),
    .count  (q_count)
  );

  rfus_solver u_solver (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_head),
    .job_valid (!q_empty),
    .job_pop   (job_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCW'(QDEPTH))
    else $error("job queue over depth");

  a_q_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (q_count != QCW'(QDEPTH)) || job_pop)
    else $error("job pushed into full queue");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.singular) |->
      (out_data.update_x == '0 && out_data.update_y == '0))
    else $error("singular result with nonzero update");

endmodule
